// ===== rtl/ims_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ims_pkg: shared types and codes of the interaction mode supervisor
// Command, mode, phase and output codes, configuration register indexes and
// reset values, and the structs passed between the supervisor's modules.
// ----------------------------------------------------------------------------
package ims_pkg;

   // Command codes. Codes 6 and 7 carry no meaning and act as no command.
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_TRACK = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_STIFF = 3'd3;
   localparam logic [2:0] CMD_FREE  = 3'd4;
   localparam logic [2:0] CMD_TEST  = 3'd5;

   // Operating modes.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_TRACK = 2'd1;
   localparam logic [1:0] MODE_STIFF = 2'd2;
   localparam logic [1:0] MODE_FREE  = 2'd3;

   // Interaction phases.
   localparam logic [1:0] PH_SETTLE = 2'd0;
   localparam logic [1:0] PH_WATCH  = 2'd1;
   localparam logic [1:0] PH_HOLD   = 2'd2;

   // Motor enable values.
   localparam logic [1:0] EN_OFF  = 2'd0;
   localparam logic [1:0] EN_ON   = 2'd1;
   localparam logic [1:0] EN_TEST = 2'd2;

   // Impedance modes and the fixed gain used while holding.
   localparam logic [1:0] IMP_NORMAL = 2'd0;
   localparam logic [1:0] IMP_STIFF  = 2'd2;
   localparam logic [1:0] IMP_FREE   = 2'd3;
   localparam logic [7:0] HOLD_GAIN  = 8'd5;

   // Configuration register indexes.
   localparam logic [2:0] REG_SETTLE_TICKS   = 3'd0;
   localparam logic [2:0] REG_DETECT_TICKS   = 3'd1;
   localparam logic [2:0] REG_RELEASE_TICKS  = 3'd2;
   localparam logic [2:0] REG_STIFF_DETECT   = 3'd3;
   localparam logic [2:0] REG_FREE_DETECT    = 3'd4;
   localparam logic [2:0] REG_STIFF_RELEASE  = 3'd5;
   localparam logic [2:0] REG_FREE_RELEASE   = 3'd6;
   localparam logic [2:0] REG_TRACK_GAIN     = 3'd7;

   // Configuration reset values.
   localparam logic [15:0] RST_SETTLE_TICKS  = 16'd4000;
   localparam logic [7:0]  RST_DETECT_TICKS  = 8'd5;
   localparam logic [15:0] RST_RELEASE_TICKS = 16'd2000;
   localparam logic [15:0] RST_STIFF_DETECT  = 16'd20;
   localparam logic [15:0] RST_FREE_DETECT   = 16'd25;
   localparam logic [10:0] RST_STIFF_RELEASE = 11'd10;
   localparam logic [10:0] RST_FREE_RELEASE  = 11'd3;
   localparam logic [7:0]  RST_TRACK_GAIN    = 8'd1;

   typedef struct packed {
      logic [15:0] settle_ticks;
      logic [7:0]  detect_ticks;
      logic [15:0] release_ticks;
      logic [15:0] stiff_detect_level;
      logic [15:0] free_detect_level;
      logic [10:0] stiff_release_level;
      logic [10:0] free_release_level;
      logic [7:0]  track_gain;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         phase;
      logic [15:0]        tick_count;
      logic signed [15:0] held_position;
   } state_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [15:0] traj_position;
      logic signed [15:0] traj_speed;
      logic signed [15:0] traj_accel;
      logic signed [15:0] interaction_level;
   } req_type;

   typedef struct packed {
      logic               drive_valid;
      logic signed [15:0] position_cmd;
      logic signed [15:0] speed_cmd;
      logic signed [15:0] accel_cmd;
      logic               advance_trajectory;
      logic               enable_valid;
      logic [1:0]         enable_value;
      logic               impedance_valid;
      logic [1:0]         impedance_mode;
      logic [7:0]         impedance_gain;
      logic [1:0]         mode_now;
      logic [1:0]         phase_now;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/ims_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ims_if: item channels of the interaction mode supervisor
// Valid/ready channels for the tick item going in and the result item going
// out, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface ims_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [15:0] traj_position;
   logic signed [15:0] traj_speed;
   logic signed [15:0] traj_accel;
   logic signed [15:0] interaction_level;

   modport source (
      output valid, command, traj_position, traj_speed, traj_accel,
             interaction_level,
      input  ready
   );
   modport sink (
      input  valid, command, traj_position, traj_speed, traj_accel,
             interaction_level,
      output ready
   );
endinterface

interface ims_rsp_if;
   logic               valid;
   logic               ready;
   logic               drive_valid;
   logic signed [15:0] position_cmd;
   logic signed [15:0] speed_cmd;
   logic signed [15:0] accel_cmd;
   logic               advance_trajectory;
   logic               enable_valid;
   logic [1:0]         enable_value;
   logic               impedance_valid;
   logic [1:0]         impedance_mode;
   logic [7:0]         impedance_gain;
   logic [1:0]         mode_now;
   logic [1:0]         phase_now;

   modport source (
      output valid, drive_valid, position_cmd, speed_cmd, accel_cmd,
             advance_trajectory, enable_valid, enable_value, impedance_valid,
             impedance_mode, impedance_gain, mode_now, phase_now,
      input  ready
   );
   modport sink (
      input  valid, drive_valid, position_cmd, speed_cmd, accel_cmd,
             advance_trajectory, enable_valid, enable_value, impedance_valid,
             impedance_mode, impedance_gain, mode_now, phase_now,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/ims_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ims_csr: configuration registers
// Holds the eight supervisor settings, loaded from the write port.
// ----------------------------------------------------------------------------
module ims_csr
   import ims_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks        <= RST_SETTLE_TICKS;
         cfg_ff.detect_ticks        <= RST_DETECT_TICKS;
         cfg_ff.release_ticks       <= RST_RELEASE_TICKS;
         cfg_ff.stiff_detect_level  <= RST_STIFF_DETECT;
         cfg_ff.free_detect_level   <= RST_FREE_DETECT;
         cfg_ff.stiff_release_level <= RST_STIFF_RELEASE;
         cfg_ff.free_release_level  <= RST_FREE_RELEASE;
         cfg_ff.track_gain          <= RST_TRACK_GAIN;
      end else if (csr_we) begin
         case (csr_index)
            REG_SETTLE_TICKS:  cfg_ff.settle_ticks        <= csr_wdata;
            REG_DETECT_TICKS:  cfg_ff.detect_ticks        <= csr_wdata[7:0];
            REG_RELEASE_TICKS: cfg_ff.release_ticks       <= csr_wdata;
            REG_STIFF_DETECT:  cfg_ff.stiff_detect_level  <= csr_wdata;
            REG_FREE_DETECT:   cfg_ff.free_detect_level   <= csr_wdata;
            REG_STIFF_RELEASE: cfg_ff.stiff_release_level <= csr_wdata[10:0];
            REG_FREE_RELEASE:  cfg_ff.free_release_level  <= csr_wdata[10:0];
            REG_TRACK_GAIN:    cfg_ff.track_gain          <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/ims_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ims_step: per-tick supervisor logic
// Applies the command, runs the mode and phase logic on the current state and
// forms the result item and the next state.
// ----------------------------------------------------------------------------
module ims_step
   import ims_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type st,
   input  req_type   item,
   output state_type st_next,
   output rsp_type   res
);

   logic        [16:0] lvl_ext;
   logic        [16:0] lvl_mag;
   logic        [10:0] lvl_shr;
   logic        [10:0] shr_mag;
   logic        [15:0] tick_inc;
   logic        [15:0] detect_th;
   logic        [10:0] release_th;
   logic        [15:0] watch_cnt;
   logic        [15:0] hold_cnt;
   logic        [1:0]  mode_cmd;
   logic        [1:0]  phase_cmd;
   logic               stiff;

   // Magnitude of the reading, and of the reading shifted right five with
   // floor rounding; both negations fit since the most negative value maps
   // to a plain power of two.
   assign lvl_ext    = {item.interaction_level[15], item.interaction_level};
   assign lvl_mag    = lvl_ext[16] ? (~lvl_ext + 17'd1) : lvl_ext;
   assign lvl_shr    = item.interaction_level[15:5];
   assign shr_mag    = lvl_shr[10] ? (~lvl_shr + 11'd1) : lvl_shr;
   assign tick_inc   = st.tick_count + 16'd1;
   assign stiff      = (mode_cmd == MODE_STIFF);
   assign detect_th  = stiff ? cfg.stiff_detect_level : cfg.free_detect_level;
   assign release_th = stiff ? cfg.stiff_release_level : cfg.free_release_level;
   assign watch_cnt  = (lvl_mag > {1'b0, detect_th}) ? tick_inc : 16'd0;
   assign hold_cnt   = (shr_mag > release_th) ? 16'd0 : st.tick_count;

   always_comb begin
      res       = '0;
      mode_cmd  = st.mode;
      phase_cmd = st.phase;

      case (item.command)
         CMD_STOP: begin
            res.enable_valid = 1'b1;
            res.enable_value = EN_OFF;
            mode_cmd         = MODE_IDLE;
            phase_cmd        = PH_SETTLE;
         end
         CMD_TRACK: begin
            res.enable_valid    = 1'b1;
            res.enable_value    = EN_ON;
            mode_cmd            = MODE_TRACK;
            res.impedance_valid = 1'b1;
            res.impedance_mode  = IMP_NORMAL;
            res.impedance_gain  = cfg.track_gain;
         end
         CMD_STIFF: begin
            res.enable_valid = 1'b1;
            res.enable_value = EN_ON;
            mode_cmd         = MODE_STIFF;
         end
         CMD_FREE: begin
            res.enable_valid = 1'b1;
            res.enable_value = EN_ON;
            mode_cmd         = MODE_FREE;
         end
         CMD_TEST: begin
            res.enable_valid = 1'b1;
            res.enable_value = EN_TEST;
            mode_cmd         = MODE_TRACK;
         end
         default: ;
      endcase

      st_next       = st;
      st_next.mode  = mode_cmd;
      st_next.phase = phase_cmd;

      case (mode_cmd)
         MODE_TRACK: begin
            res.drive_valid        = 1'b1;
            res.advance_trajectory = 1'b1;
            res.position_cmd       = item.traj_position;
            res.speed_cmd          = item.traj_speed;
            res.accel_cmd          = item.traj_accel;
         end
         MODE_STIFF, MODE_FREE: begin
            case (phase_cmd)
               PH_SETTLE: begin
                  res.drive_valid        = 1'b1;
                  res.advance_trajectory = 1'b1;
                  res.position_cmd       = item.traj_position;
                  res.speed_cmd          = item.traj_speed;
                  res.accel_cmd          = item.traj_accel;
                  if (st.tick_count >= cfg.settle_ticks) begin
                     st_next.tick_count = 16'd0;
                     st_next.phase      = PH_WATCH;
                  end else begin
                     st_next.tick_count = tick_inc;
                  end
               end
               PH_WATCH: begin
                  res.drive_valid        = 1'b1;
                  res.advance_trajectory = 1'b1;
                  res.position_cmd       = item.traj_position;
                  res.speed_cmd          = item.traj_speed;
                  res.accel_cmd          = item.traj_accel;
                  if (watch_cnt >= {8'd0, cfg.detect_ticks}) begin
                     st_next.held_position = item.traj_position;
                     st_next.phase         = PH_HOLD;
                     st_next.tick_count    = 16'd0;
                  end else begin
                     st_next.tick_count = watch_cnt;
                  end
               end
               default: begin
                  // Hold; an unused phase code behaves the same way.
                  res.drive_valid     = 1'b1;
                  res.position_cmd    = stiff ? st.held_position : 16'sd0;
                  res.impedance_valid = 1'b1;
                  res.impedance_mode  = stiff ? IMP_STIFF : IMP_FREE;
                  res.impedance_gain  = HOLD_GAIN;
                  if (hold_cnt >= cfg.release_ticks) begin
                     st_next.phase      = PH_SETTLE;
                     st_next.tick_count = 16'd0;
                     res.impedance_mode = IMP_NORMAL;
                     res.impedance_gain = 8'd0;
                  end else begin
                     st_next.tick_count = hold_cnt + 16'd1;
                  end
               end
            endcase
         end
         default: ;
      endcase

      res.mode_now  = st_next.mode;
      res.phase_now = st_next.phase;
   end

endmodule
`default_nettype wire

// ===== rtl/interaction_mode_supervisor_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// interaction_mode_supervisor_unit: mode and phase supervisor for a drive
// Turns one control tick item (command, trajectory sample, interaction
// reading) into one result item of drive, enable and impedance writes.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake          Contents
//   req_chan   in         valid/ready        command, trajectory, reading
//   rsp_chan   out        valid/ready        drive, enable, impedance writes
//   csr_*      in         write enable only  index 0..7, 16-bit data
//
// Each item is taken into the input register and moves on to the result
// register as soon as that register is empty or its result is being taken;
// one item is taken every cycle while each result is accepted as soon as it
// is presented. The supervisor state (mode, phase, tick counter, held
// position) is updated as an item moves from the input register to the
// result register, so the next item always sees it.
// When both registers are full and the result is not taken, the input
// register holds its item and req_chan.ready drops until the result moves on.
// Reset is synchronous: it empties both registers, returns the state to idle
// and settle with a zero count and held position, and loads the default
// settings.
//
module interaction_mode_supervisor_unit
   import ims_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   ims_req_if.sink          req_chan,
   ims_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type   cfg;
   state_type st_ff;
   state_type st_in;
   req_type   item_ff;
   req_type   item_in;
   rsp_type   res_ff;
   rsp_type   res_in;
   logic      item_valid_ff;
   logic      res_valid_ff;
   logic      move;
   logic      take;

   ims_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ims_step u_step (
      .cfg     (cfg),
      .st      (st_ff),
      .item    (item_ff),
      .st_next (st_in),
      .res     (res_in)
   );

   // The item in the input register moves on whenever the result register
   // is empty or its item is being taken this cycle.
   assign move = item_valid_ff && (!res_valid_ff || rsp_chan.ready);
   assign take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !item_valid_ff || !res_valid_ff || rsp_chan.ready;

   assign item_in.command           = req_chan.command;
   assign item_in.traj_position     = req_chan.traj_position;
   assign item_in.traj_speed        = req_chan.traj_speed;
   assign item_in.traj_accel        = req_chan.traj_accel;
   assign item_in.interaction_level = req_chan.interaction_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
         st_ff         <= '{mode: MODE_IDLE, phase: PH_SETTLE,
                            tick_count: 16'd0, held_position: 16'sd0};
      end else begin
         if (take) begin
            item_valid_ff <= 1'b1;
         end else if (move) begin
            item_valid_ff <= 1'b0;
         end
         if (move) begin
            res_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_chan.ready) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (move) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid              = res_valid_ff;
   assign rsp_chan.drive_valid        = res_ff.drive_valid;
   assign rsp_chan.position_cmd       = res_ff.position_cmd;
   assign rsp_chan.speed_cmd          = res_ff.speed_cmd;
   assign rsp_chan.accel_cmd          = res_ff.accel_cmd;
   assign rsp_chan.advance_trajectory = res_ff.advance_trajectory;
   assign rsp_chan.enable_valid       = res_ff.enable_valid;
   assign rsp_chan.enable_value       = res_ff.enable_value;
   assign rsp_chan.impedance_valid    = res_ff.impedance_valid;
   assign rsp_chan.impedance_mode     = res_ff.impedance_mode;
   assign rsp_chan.impedance_gain     = res_ff.impedance_gain;
   assign rsp_chan.mode_now           = res_ff.mode_now;
   assign rsp_chan.phase_now          = res_ff.phase_now;

endmodule
`default_nettype wire

// ===== rtl/ims_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ims_checker: port checks for the interaction mode supervisor
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module ims_checker
   import ims_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        drive_valid,
   input wire logic [15:0] position_cmd,
   input wire logic [15:0] speed_cmd,
   input wire logic [15:0] accel_cmd,
   input wire logic        advance_trajectory,
   input wire logic        enable_valid,
   input wire logic [1:0]  enable_value,
   input wire logic        impedance_valid,
   input wire logic [1:0]  impedance_mode,
   input wire logic [7:0]  impedance_gain,
   input wire logic [1:0]  mode_now
);

   // A result that waits stays valid and keeps its position, gain and mode.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(position_cmd)
         && $stable(impedance_gain) && $stable(mode_now))
      else $error("waiting result changed");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Fields not written are zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (drive_valid || (position_cmd == 16'd0 && speed_cmd == 16'd0
         && accel_cmd == 16'd0)) && (enable_valid || enable_value == EN_OFF)
         && (impedance_valid || (impedance_mode == IMP_NORMAL
         && impedance_gain == 8'd0)))
      else $error("unwritten field not zero");

   // Tracking always drives and consumes the sample; idle never drives; a sample is consumed only while driving.
   a_track_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mode_now != MODE_TRACK || (drive_valid && advance_trajectory))
         && (mode_now != MODE_IDLE || !drive_valid)
         && (!advance_trajectory || drive_valid))
      else $error("drive writes do not match mode");

endmodule

bind interaction_mode_supervisor_unit ims_checker u_ims_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .drive_valid        (rsp_chan.drive_valid),
   .position_cmd       (rsp_chan.position_cmd),
   .speed_cmd          (rsp_chan.speed_cmd),
   .accel_cmd          (rsp_chan.accel_cmd),
   .advance_trajectory (rsp_chan.advance_trajectory),
   .enable_valid       (rsp_chan.enable_valid),
   .enable_value       (rsp_chan.enable_value),
   .impedance_valid    (rsp_chan.impedance_valid),
   .impedance_mode     (rsp_chan.impedance_mode),
   .impedance_gain     (rsp_chan.impedance_gain),
   .mode_now           (rsp_chan.mode_now)
);
`default_nettype wire

// ===== dv/ims_supervisor_checker.sv =====
// ----------------------------------------------------------------------------
// ims_supervisor_checker: result checker for the interaction mode supervisor
// Watches both item channels and the register write port, keeps its own copy
// of the supervisor state and settings, predicts the result of every accepted
// tick item and compares each accepted result item against the oldest one.
// ----------------------------------------------------------------------------
module ims_supervisor_checker
   import ims_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   ims_req_if               req_mon,
   ims_rsp_if               rsp_mon,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               results_due
);

   cfg_type            settings;
   logic [1:0]         mode_q;
   logic [1:0]         phase_q;
   logic [15:0]        ticks_q;
   logic signed [15:0] held_q;
   rsp_type            writes_due[$];
   rsp_type            predicted;
   rsp_type            oldest;

   initial begin
      fail_count  = 0;
      results_due = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   // One control tick: the command is applied first, then the mode chosen by
   // it runs its settle, watch or hold step in the same tick.
   task automatic supervise_tick(
      input  logic [2:0]         cmd,
      input  logic signed [15:0] traj_pos,
      input  logic signed [15:0] traj_spd,
      input  logic signed [15:0] traj_acc,
      input  logic signed [15:0] level,
      output rsp_type            r
   );
      int   level_mag;
      int   coarse_mag;
      int   threshold;
      logic stiff;
      r          = '0;
      level_mag  = int'(level);
      coarse_mag = level_mag >>> 5;
      level_mag  = (level_mag < 0) ? -level_mag : level_mag;
      coarse_mag = (coarse_mag < 0) ? -coarse_mag : coarse_mag;

      case (cmd)
         CMD_STOP: begin
            r.enable_valid = 1'b1;
            r.enable_value = EN_OFF;
            mode_q         = MODE_IDLE;
            phase_q        = PH_SETTLE;
         end
         CMD_TRACK: begin
            r.enable_valid    = 1'b1;
            r.enable_value    = EN_ON;
            mode_q            = MODE_TRACK;
            r.impedance_valid = 1'b1;
            r.impedance_mode  = IMP_NORMAL;
            r.impedance_gain  = settings.track_gain;
         end
         CMD_STIFF: begin
            r.enable_valid = 1'b1;
            r.enable_value = EN_ON;
            mode_q         = MODE_STIFF;
         end
         CMD_FREE: begin
            r.enable_valid = 1'b1;
            r.enable_value = EN_ON;
            mode_q         = MODE_FREE;
         end
         CMD_TEST: begin
            r.enable_valid = 1'b1;
            r.enable_value = EN_TEST;
            mode_q         = MODE_TRACK;
         end
         default: begin
         end
      endcase

      if (mode_q == MODE_TRACK) begin
         r.drive_valid        = 1'b1;
         r.advance_trajectory = 1'b1;
         r.position_cmd       = traj_pos;
         r.speed_cmd          = traj_spd;
         r.accel_cmd          = traj_acc;
      end else if (mode_q == MODE_STIFF || mode_q == MODE_FREE) begin
         stiff = (mode_q == MODE_STIFF);
         if (phase_q == PH_SETTLE) begin
            r.drive_valid        = 1'b1;
            r.advance_trajectory = 1'b1;
            r.position_cmd       = traj_pos;
            r.speed_cmd          = traj_spd;
            r.accel_cmd          = traj_acc;
            if (ticks_q >= settings.settle_ticks) begin
               ticks_q = '0;
               phase_q = PH_WATCH;
            end else begin
               ticks_q = ticks_q + 16'd1;
            end
         end else if (phase_q == PH_WATCH) begin
            threshold = stiff ? int'(settings.stiff_detect_level)
                              : int'(settings.free_detect_level);
            r.drive_valid        = 1'b1;
            r.advance_trajectory = 1'b1;
            r.position_cmd       = traj_pos;
            r.speed_cmd          = traj_spd;
            r.accel_cmd          = traj_acc;
            if (level_mag > threshold) begin
               ticks_q = ticks_q + 16'd1;
            end else begin
               ticks_q = '0;
            end
            if (ticks_q >= 16'(settings.detect_ticks)) begin
               held_q  = traj_pos;
               phase_q = PH_HOLD;
               ticks_q = '0;
            end
         end else begin
            // Hold: the free mode commands position zero, not the held one.
            threshold = stiff ? int'(settings.stiff_release_level)
                              : int'(settings.free_release_level);
            r.drive_valid     = 1'b1;
            r.position_cmd    = stiff ? held_q : 16'sd0;
            r.impedance_valid = 1'b1;
            r.impedance_mode  = stiff ? IMP_STIFF : IMP_FREE;
            r.impedance_gain  = HOLD_GAIN;
            if (coarse_mag > threshold) begin
               ticks_q = '0;
            end
            if (ticks_q >= settings.release_ticks) begin
               phase_q          = PH_SETTLE;
               ticks_q          = '0;
               r.impedance_mode = IMP_NORMAL;
               r.impedance_gain = 8'd0;
            end else begin
               ticks_q = ticks_q + 16'd1;
            end
         end
      end

      r.mode_now  = mode_q;
      r.phase_now = phase_q;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.settle_ticks        = RST_SETTLE_TICKS;
         settings.detect_ticks        = RST_DETECT_TICKS;
         settings.release_ticks       = RST_RELEASE_TICKS;
         settings.stiff_detect_level  = RST_STIFF_DETECT;
         settings.free_detect_level   = RST_FREE_DETECT;
         settings.stiff_release_level = RST_STIFF_RELEASE;
         settings.free_release_level  = RST_FREE_RELEASE;
         settings.track_gain          = RST_TRACK_GAIN;
         mode_q  = MODE_IDLE;
         phase_q = PH_SETTLE;
         ticks_q = '0;
         held_q  = '0;
         writes_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (writes_due.size() == 0) begin
               report_mismatch("result item arrived with no tick item outstanding");
            end else begin
               oldest = writes_due.pop_front();
               check_field("drive_valid", int'(rsp_mon.drive_valid),
                           int'(oldest.drive_valid));
               check_field("position_cmd", int'(rsp_mon.position_cmd),
                           int'(oldest.position_cmd));
               check_field("speed_cmd", int'(rsp_mon.speed_cmd),
                           int'(oldest.speed_cmd));
               check_field("accel_cmd", int'(rsp_mon.accel_cmd),
                           int'(oldest.accel_cmd));
               check_field("advance_trajectory", int'(rsp_mon.advance_trajectory),
                           int'(oldest.advance_trajectory));
               check_field("enable_valid", int'(rsp_mon.enable_valid),
                           int'(oldest.enable_valid));
               check_field("enable_value", int'(rsp_mon.enable_value),
                           int'(oldest.enable_value));
               check_field("impedance_valid", int'(rsp_mon.impedance_valid),
                           int'(oldest.impedance_valid));
               check_field("impedance_mode", int'(rsp_mon.impedance_mode),
                           int'(oldest.impedance_mode));
               check_field("impedance_gain", int'(rsp_mon.impedance_gain),
                           int'(oldest.impedance_gain));
               check_field("mode_now", int'(rsp_mon.mode_now),
                           int'(oldest.mode_now));
               check_field("phase_now", int'(rsp_mon.phase_now),
                           int'(oldest.phase_now));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            supervise_tick(req_mon.command, req_mon.traj_position, req_mon.traj_speed,
                           req_mon.traj_accel, req_mon.interaction_level, predicted);
            writes_due.push_back(predicted);
         end
         if (csr_we) begin
            case (csr_index)
               REG_SETTLE_TICKS:  settings.settle_ticks        = csr_wdata;
               REG_DETECT_TICKS:  settings.detect_ticks        = csr_wdata[7:0];
               REG_RELEASE_TICKS: settings.release_ticks       = csr_wdata;
               REG_STIFF_DETECT:  settings.stiff_detect_level  = csr_wdata;
               REG_FREE_DETECT:   settings.free_detect_level   = csr_wdata;
               REG_STIFF_RELEASE: settings.stiff_release_level = csr_wdata[10:0];
               REG_FREE_RELEASE:  settings.free_release_level  = csr_wdata[10:0];
               REG_TRACK_GAIN:    settings.track_gain          = csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
      results_due = writes_due.size();
   end

endmodule

// ===== dv/interaction_mode_supervisor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// interaction_mode_supervisor_unit_tb: top level of the supervisor testbench
// Drives tick items and register writes into the supervisor, stalls the
// result channel, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module interaction_mode_supervisor_unit_tb;
   import ims_pkg::*;

   // Cycles without any accepted item before the run is declared hung. The
   // slowest stretch is a long run of receiver stalls at the heavy stall rate
   // plus a full register rewrite, which is far below this.
   localparam int WATCHDOG_LIMIT = 4000;

   // How a tick's reading is drawn: well above any randomly set detect level,
   // quiet in hold for release levels of two or more, or any 16-bit value.
   typedef enum int {LVL_LOUD, LVL_QUIET, LVL_WILD} level_style_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int      fail_count;
   int      results_due;
   int      send_idle_pct;
   int      rsp_stall_pct;
   int      idle_cycles;
   int      segment_items;
   cfg_type plan;

   ims_req_if req_chan ();
   ims_rsp_if rsp_chan ();

   interaction_mode_supervisor_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ims_supervisor_checker supervisor_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // The receiver takes a result on a random share of cycles. The stall rate
   // is changed by the stimulus process as the run moves between windows.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // The watchdog is restarted by every accepted item on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL interaction_mode_supervisor_unit");
         $finish;
      end
   end

   // Presents one tick item. It is called at a falling edge and returns at
   // the falling edge after the item was taken, with valid still high so a
   // following item can go out back to back. Before the item the sender may
   // idle for a few cycles at the current idle rate.
   task automatic send_tick(input logic [2:0] cmd, input int pos, input int spd,
                            input int acc, input int level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.command           <= cmd;
      req_chan.traj_position     <= 16'(pos);
      req_chan.traj_speed        <= 16'(spd);
      req_chan.traj_accel        <= 16'(acc);
      req_chan.interaction_level <= 16'(level);
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      segment_items++;
      @(negedge clock);
   endtask

   // Stops sending and waits until the result of every accepted tick has
   // come back. Every tick gives exactly one result, so the block is idle
   // once nothing is outstanding.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Writes all eight registers, one per cycle, and remembers the settings
   // so that the episode lengths can follow them.
   task automatic apply_settings(input cfg_type s);
      plan = s;
      write_reg(REG_SETTLE_TICKS, s.settle_ticks);
      write_reg(REG_DETECT_TICKS, 16'(s.detect_ticks));
      write_reg(REG_RELEASE_TICKS, s.release_ticks);
      write_reg(REG_STIFF_DETECT, s.stiff_detect_level);
      write_reg(REG_FREE_DETECT, s.free_detect_level);
      write_reg(REG_STIFF_RELEASE, 16'(s.stiff_release_level));
      write_reg(REG_FREE_RELEASE, 16'(s.free_release_level));
      write_reg(REG_TRACK_GAIN, 16'(s.track_gain));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Small settings keep the settle, detect and release counts short, so
   // that many full interaction episodes fit into the run.
   function automatic cfg_type random_settings();
      cfg_type s;
      s.settle_ticks        = 16'($urandom_range(8));
      s.detect_ticks        = 8'($urandom_range(5));
      s.release_ticks       = 16'($urandom_range(8));
      s.stiff_detect_level  = 16'($urandom_range(300));
      s.free_detect_level   = 16'($urandom_range(300));
      s.stiff_release_level = 11'($urandom_range(12));
      s.free_release_level  = 11'($urandom_range(12));
      s.track_gain          = 8'($urandom);
      return s;
   endfunction

   function automatic int random_level(input level_style_type style);
      int magnitude;
      magnitude = 0;
      case (style)
         LVL_LOUD: begin
            if ($urandom_range(19) == 0) begin
               return -32768;
            end
            magnitude = $urandom_range(32767, 1000);
         end
         LVL_QUIET: magnitude = $urandom_range(40);
         default: return int'(16'($urandom));
      endcase
      return $urandom_range(1) ? -magnitude : magnitude;
   endfunction

   task automatic send_random_tick(input logic [2:0] cmd, input level_style_type style);
      send_tick(cmd, int'(16'($urandom)), int'(16'($urandom)), int'(16'($urandom)),
                random_level(style));
   endtask

   // One interaction: an interact command, ticks to leave settle, loud readings
   // to reach hold, then quiet ones until the release, each run capped for large
   // counts. Now and then a quiet reading breaks the loud run or a loud one
   // interrupts the quiet stretch, and a few episodes end in a stop.
   task automatic run_episode();
      int settle_len;
      int loud_len;
      int quiet_len;
      settle_len = ((plan.settle_ticks > 16'd39) ? 40 : int'(plan.settle_ticks) + 1)
                   + $urandom_range(2);
      loud_len   = ((plan.detect_ticks > 8'd39) ? 40 : int'(plan.detect_ticks))
                   + $urandom_range(2);
      quiet_len  = ((plan.release_ticks > 16'd39) ? 40 : int'(plan.release_ticks) + 1)
                   + $urandom_range(3);
      send_random_tick($urandom_range(1) ? CMD_STIFF : CMD_FREE, LVL_WILD);
      repeat (settle_len) begin
         send_random_tick(CMD_NONE, LVL_WILD);
      end
      repeat (loud_len) begin
         send_random_tick(CMD_NONE, ($urandom_range(11) == 0) ? LVL_QUIET : LVL_LOUD);
      end
      repeat (quiet_len) begin
         send_random_tick(CMD_NONE, ($urandom_range(19) == 0) ? LVL_LOUD : LVL_QUIET);
      end
      if ($urandom_range(9) == 0) begin
         send_random_tick(CMD_STOP, LVL_WILD);
      end
   endtask

   // A short burst of arbitrary commands, the unused codes among them, with
   // arbitrary readings.
   task automatic run_noise();
      repeat ($urandom_range(8, 1)) begin
         send_random_tick($urandom_range(1) ? CMD_NONE : 3'($urandom_range(7)), LVL_WILD);
      end
   endtask

   // One stretch of random stimulus under one set of register values. The
   // block is idle when the registers are written. Once in a while the
   // sender also holds off until every outstanding result has come back.
   task automatic run_segment(input cfg_type s, input int items);
      drain_results();
      apply_settings(s);
      segment_items = 0;
      while (segment_items < items) begin
         if ($urandom_range(9) < 7) begin
            run_episode();
         end else begin
            run_noise();
         end
         if ($urandom_range(29) == 0) begin
            drain_results();
         end
      end
   endtask

   initial begin
      reset                      = 1'b1;
      csr_we                     = 1'b0;
      csr_index                  = REG_SETTLE_TICKS;
      csr_wdata                  = '0;
      req_chan.valid             = 1'b0;
      req_chan.command           = CMD_NONE;
      req_chan.traj_position     = '0;
      req_chan.traj_speed        = '0;
      req_chan.traj_accel        = '0;
      req_chan.interaction_level = '0;
      send_idle_pct              = 0;
      rsp_stall_pct              = 0;
      idle_cycles                = 0;
      segment_items              = 0;
      plan                       = random_settings();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset settings. With the long default settle
      // count the interact modes stay in settle here; these ticks cover every
      // command, the two unused codes, and the extremes of every field.
      send_tick(CMD_NONE, 0, 0, 0, 0);
      send_tick(CMD_NONE, 32767, -32768, -1, 32767);
      send_tick(CMD_TRACK, -32768, 32767, 0, -32768);
      send_tick(CMD_NONE, 32767, -32768, -1, -1);
      send_tick(CMD_TEST, 1234, -1234, 32767, 0);
      send_tick(3'd6, -1, 1, -32768, 32767);
      send_tick(3'd7, 77, -77, 5, -32768);
      send_tick(CMD_STOP, 100, 200, 300, 400);
      send_tick(CMD_STIFF, -5, 6, -7, 8);
      send_tick(CMD_FREE, 9, -10, 11, -12);
      send_tick(CMD_STOP, 0, 0, 0, 0);

      // Short counts so that a directed walk reaches every phase: stiff mode
      // settles, sees two readings just above its level, holds, and releases
      // after a full-scale reading resets the quiet count. Free mode is then
      // chosen twice, which keeps its phase, reaches hold with position zero,
      // and releases on a reading just at the free release level.
      drain_results();
      apply_settings('{settle_ticks: 16'd1, detect_ticks: 8'd2, release_ticks: 16'd1,
                       stiff_detect_level: 16'd20, free_detect_level: 16'd25,
                       stiff_release_level: 11'd10, free_release_level: 11'd3,
                       track_gain: 8'd77});
      send_tick(CMD_STIFF, 500, 50, 5, 0);
      send_tick(CMD_NONE, 600, 60, 6, -21);
      send_tick(CMD_NONE, 700, 70, 7, 21);
      send_tick(CMD_NONE, 800, 80, 8, -32768);
      send_tick(CMD_NONE, 900, 90, 9, 319);
      send_tick(CMD_FREE, -500, -50, -5, 0);
      send_tick(CMD_FREE, -600, -60, -6, 0);
      send_tick(CMD_NONE, -700, -70, -7, 26);
      send_tick(CMD_NONE, -800, -80, -8, -26);
      send_tick(CMD_NONE, -900, -90, -9, -97);
      send_tick(CMD_NONE, -1000, -100, -10, 127);
      send_tick(CMD_TRACK, 1, 2, 3, 4);

      // First window: the sender idles now and then, the receiver stalls on
      // most cycles. Its second segment uses the top detect and release counts.
      send_idle_pct = 26;
      rsp_stall_pct = 81;
      run_segment(random_settings(), 150);
      run_segment('{settle_ticks: 16'd0, detect_ticks: 8'd255, release_ticks: 16'd65535,
                    stiff_detect_level: 16'd0, free_detect_level: 16'd32768,
                    stiff_release_level: 11'd1024, free_release_level: 11'd1024,
                    track_gain: 8'd255}, 60);

      // Second window: the roles are swapped. The second segment uses zero
      // everywhere, which lets the watch phase enter hold on its first tick.
      send_idle_pct = 81;
      rsp_stall_pct = 26;
      run_segment(random_settings(), 150);
      run_segment('{settle_ticks: 16'd0, detect_ticks: 8'd0, release_ticks: 16'd0,
                    stiff_detect_level: 16'd0, free_detect_level: 16'd0,
                    stiff_release_level: 11'd0, free_release_level: 11'd0,
                    track_gain: 8'd0}, 120);

      // Last window: both sides run at full rate. The final segment has the
      // longest settle count, so a new episode waits in settle throughout.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_segment(random_settings(), 230);
      run_segment('{settle_ticks: 16'd65535, detect_ticks: 8'd1, release_ticks: 16'd1,
                    stiff_detect_level: 16'd32768, free_detect_level: 16'd0,
                    stiff_release_level: 11'd0, free_release_level: 11'd1024,
                    track_gain: 8'd128}, 40);

      // Let every outstanding result arrive, then a few more cycles so that
      // a stray extra result would still be seen.
      drain_results();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS interaction_mode_supervisor_unit");
      end else begin
         $display("FAIL interaction_mode_supervisor_unit");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ims_pkg.sv
rtl/ims_if.sv
rtl/ims_csr.sv
rtl/ims_step.sv
rtl/interaction_mode_supervisor_unit.sv
rtl/ims_checker.sv
dv/ims_supervisor_checker.sv
dv/interaction_mode_supervisor_unit_tb.sv
